### hdl/ple_pkg.sv
// ----------------------------------------------------------------------------
// ple_pkg
// Operation codes, status codes and field widths of the positional list engine.
// ----------------------------------------------------------------------------
package ple_pkg;

  localparam int unsigned FuncW   = 3;
  localparam int unsigned ValueW  = 32;
  localparam int unsigned PosW    = 7;
  localparam int unsigned StatusW = 3;

  typedef logic [FuncW-1:0]   func_t;
  typedef logic [StatusW-1:0] status_t;

  localparam func_t F_INS_FRONT = 3'd0;
  localparam func_t F_INS_END   = 3'd1;
  localparam func_t F_INS_POS   = 3'd2;
  localparam func_t F_DEL_FRONT = 3'd3;
  localparam func_t F_DEL_END   = 3'd4;
  localparam func_t F_DEL_POS   = 3'd5;
  localparam func_t F_SEARCH    = 3'd6;
  localparam func_t F_DUMP      = 3'd7;

  localparam status_t ST_OK           = 3'd0;
  localparam status_t ST_EMPTY        = 3'd1;
  localparam status_t ST_BELOW_ONE    = 3'd2;
  localparam status_t ST_OUT_OF_BOUND = 3'd3;
  localparam status_t ST_FULL         = 3'd4;
  localparam status_t ST_NOT_FOUND    = 3'd5;

endpackage

### hdl/positional_list_engine.sv
// Error results and end deletes go from acceptance straight to the response state.
// Insert/delete: a store read and a write per moved element; search: a read and a compare each.
// Dump: a read and an output step per element, held while the output stalls; one transaction in
// flight at a time, the next accepted in the cycle after the final result loads.
// The sequencer alternates a registered store read with an execute step per element.
// Reset clears the element count and output valid; store contents are undefined.
// ----------------------------------------------------------------------------
// positional_list_engine
// Ordered list of signed 32-bit values kept packed in a RAM with a count; a
// small sequencer shifts, compares and dumps elements one at a time.
// ----------------------------------------------------------------------------
module positional_list_engine
  import ple_pkg::*;
#(
  parameter int unsigned CAPACITY = 16
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  logic [FuncW-1:0]         func_i,
  input  logic signed [ValueW-1:0] value_i,
  input  logic [PosW-1:0]          position_i,
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output logic [StatusW-1:0]       status_o,
  output logic signed [ValueW-1:0] element_o,
  output logic [PosW-1:0]          found_at_o,
  output logic                     last_o
);

  localparam int unsigned AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CW = $clog2(CAPACITY + 1);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_RD   = 3'd1;
  localparam logic [2:0] S_EXE  = 3'd2;
  localparam logic [2:0] S_PUT  = 3'd3;
  localparam logic [2:0] S_DROP = 3'd4;
  localparam logic [2:0] S_RESP = 3'd5;

  logic [2:0]         state_q, state_d;
  func_t              func_q, func_d;
  logic [ValueW-1:0]  val_q, val_d;
  logic [AW-1:0]      idx_q, idx_d;
  logic [AW-1:0]      ptr_q, ptr_d;
  logic [CW-1:0]      count_q, count_d;
  status_t            res_status_q, res_status_d;
  logic [PosW-1:0]    res_found_q, res_found_d;

  logic [ValueW-1:0]  mem_q [CAPACITY];
  logic [ValueW-1:0]  rd_data_q;
  logic               rd_en, wr_en;
  logic [AW-1:0]      rd_addr, wr_addr;
  logic [ValueW-1:0]  wr_data;

  logic               out_valid_q;
  status_t            status_q;
  logic [ValueW-1:0]  element_q;
  logic [PosW-1:0]    found_q;
  logic               last_q;
  logic               out_load;
  status_t            out_status;
  logic [ValueW-1:0]  out_element;
  logic [PosW-1:0]    out_found;
  logic               out_last;
  logic               out_free;

  logic               is_ins, is_del;
  logic [PosW:0]      pos_x, cnt_x;
  logic [AW-1:0]      new_idx;
  status_t            err;
  logic               has_err;

  assign out_free   = !out_valid_q || !out_stall_i;
  assign in_stall_o = (state_q != S_IDLE);
  assign is_ins     = (func_q == F_INS_FRONT) || (func_q == F_INS_END) || (func_q == F_INS_POS);
  assign is_del     = (func_q == F_DEL_FRONT) || (func_q == F_DEL_POS);
  assign pos_x      = {1'b0, position_i};
  assign cnt_x      = (PosW + 1)'(count_q);

  always_comb begin
    state_d      = state_q;
    func_d       = func_q;
    val_d        = val_q;
    idx_d        = idx_q;
    ptr_d        = ptr_q;
    count_d      = count_q;
    res_status_d = res_status_q;
    res_found_d  = res_found_q;
    rd_en        = 1'b0;
    rd_addr      = ptr_q;
    wr_en        = 1'b0;
    wr_addr      = ptr_q;
    wr_data      = rd_data_q;
    out_load     = 1'b0;
    out_status   = ST_OK;
    out_element  = '0;
    out_found    = '0;
    out_last     = 1'b1;
    new_idx      = '0;
    err          = ST_OK;
    has_err      = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          func_d       = func_i;
          val_d        = value_i;
          res_found_d  = '0;
          res_status_d = ST_OK;
          unique case (func_i)
            F_INS_FRONT, F_INS_END, F_INS_POS: begin
              if (func_i == F_INS_END) begin
                new_idx = AW'(count_q);
              end else if (func_i == F_INS_POS) begin
                new_idx = AW'(position_i - 1'b1);
              end
              if (func_i == F_INS_POS && position_i == '0) begin
                has_err = 1'b1;
                err     = ST_BELOW_ONE;
              end else if (func_i == F_INS_POS && pos_x > cnt_x + 1'b1) begin
                has_err = 1'b1;
                err     = ST_OUT_OF_BOUND;
              end else if (count_q == CW'(CAPACITY)) begin
                has_err = 1'b1;
                err     = ST_FULL;
              end
              if (has_err) begin
                res_status_d = err;
                state_d      = S_RESP;
              end else begin
                idx_d = new_idx;
                ptr_d = AW'(count_q);
                if (AW'(count_q) > new_idx) begin
                  state_d = S_RD;
                end else begin
                  state_d = S_PUT;
                end
              end
            end
            F_DEL_FRONT, F_DEL_POS: begin
              if (func_i == F_DEL_POS) begin
                new_idx = AW'(position_i - 1'b1);
              end
              if (func_i == F_DEL_POS && position_i == '0) begin
                has_err = 1'b1;
                err     = ST_BELOW_ONE;
              end else if (count_q == '0 && (func_i == F_DEL_FRONT || position_i == PosW'(1))) begin
                has_err = 1'b1;
                err     = ST_EMPTY;
              end else if (func_i == F_DEL_POS && pos_x > cnt_x) begin
                has_err = 1'b1;
                err     = ST_OUT_OF_BOUND;
              end
              if (has_err) begin
                res_status_d = err;
                state_d      = S_RESP;
              end else begin
                ptr_d = new_idx;
                if (CW'(new_idx) + 1'b1 < count_q) begin
                  state_d = S_RD;
                end else begin
                  state_d = S_DROP;
                end
              end
            end
            F_DEL_END: begin
              if (count_q == '0) begin
                res_status_d = ST_EMPTY;
              end else begin
                count_d = count_q - 1'b1;
              end
              state_d = S_RESP;
            end
            F_SEARCH, F_DUMP: begin
              ptr_d = '0;
              if (count_q == '0) begin
                res_status_d = ST_EMPTY;
                state_d      = S_RESP;
              end else begin
                state_d = S_RD;
              end
            end
            default: ;
          endcase
        end
      end
      S_RD: begin
        rd_en = 1'b1;
        if (is_ins) begin
          rd_addr = ptr_q - 1'b1;
        end else if (is_del) begin
          rd_addr = ptr_q + 1'b1;
        end
        state_d = S_EXE;
      end
      S_EXE: begin
        if (is_ins) begin
          wr_en = 1'b1;
          ptr_d = ptr_q - 1'b1;
          if (ptr_q - 1'b1 > idx_q) begin
            state_d = S_RD;
          end else begin
            state_d = S_PUT;
          end
        end else if (is_del) begin
          wr_en = 1'b1;
          ptr_d = ptr_q + 1'b1;
          if (CW'(ptr_q) + CW'(2) < count_q) begin
            state_d = S_RD;
          end else begin
            state_d = S_DROP;
          end
        end else if (func_q == F_SEARCH) begin
          if (rd_data_q == val_q) begin
            res_status_d = ST_OK;
            res_found_d  = PosW'(ptr_q) + 1'b1;
            state_d      = S_RESP;
          end else if (CW'(ptr_q) + 1'b1 == count_q) begin
            res_status_d = ST_NOT_FOUND;
            state_d      = S_RESP;
          end else begin
            ptr_d   = ptr_q + 1'b1;
            state_d = S_RD;
          end
        end else if (out_free) begin
          out_load    = 1'b1;
          out_element = rd_data_q;
          out_last    = (CW'(ptr_q) + 1'b1 == count_q);
          if (out_last) begin
            state_d = S_IDLE;
          end else begin
            ptr_d   = ptr_q + 1'b1;
            state_d = S_RD;
          end
        end
      end
      S_PUT: begin
        wr_en   = 1'b1;
        wr_addr = idx_q;
        wr_data = val_q;
        count_d = count_q + 1'b1;
        state_d = S_RESP;
      end
      S_DROP: begin
        count_d = count_q - 1'b1;
        state_d = S_RESP;
      end
      S_RESP: begin
        if (out_free) begin
          out_load    = 1'b1;
          out_status  = res_status_q;
          out_element = (func_q == F_SEARCH) ? val_q : '0;
          out_found   = res_found_q;
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    func_q       <= func_d;
    val_q        <= val_d;
    idx_q        <= idx_d;
    ptr_q        <= ptr_d;
    res_status_q <= res_status_d;
    res_found_q  <= res_found_d;
    if (out_load) begin
      status_q  <= out_status;
      element_q <= out_element;
      found_q   <= out_found;
      last_q    <= out_last;
    end
  end

  // element store
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_q <= mem_q[rd_addr];
    end
  end

  assign out_valid_o = out_valid_q;
  assign status_o    = status_q;
  assign element_o   = element_q;
  assign found_at_o  = found_q;
  assign last_o      = last_q;

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(CAPACITY))
    else $error("element count above capacity");

  a_count_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q != $past(count_q)) |->
      (count_q == CW'($past(count_q) + 1'b1) || count_q == CW'($past(count_q) - 1'b1)))
    else $error("element count moved by more than one");

  a_found_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && found_at_o != '0) |-> (status_o == ST_OK))
    else $error("found position with non-ok status");

  a_notlast_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !last_o) |-> (status_o == ST_OK && found_at_o == '0))
    else $error("non-final result outside a dump");
`endif

endmodule
